// ----- hdl/gbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_pkg: shared types and constants for the GBM path step unit
// Holds the controller state, command and status structs and exp constants.
// ----------------------------------------------------------------------------
package gbm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NOISE,
        ST_EXPO,
        ST_LOG2,
        ST_SPLIT,
        ST_TAB,
        ST_LIN,
        ST_LINMUL,
        ST_SCALE,
        ST_SCALE2,
        ST_ROUND,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        REG_INIT  = 3'd0,
        REG_DRIFT = 3'd1,
        REG_GAIN  = 3'd2,
        REG_TSTEP = 3'd3,
        REG_LOG   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic load;    // capture input beat
        logic noise;   // gain * sample
        logic expo;    // add drift
        logic log2m;   // multiply by log2(e)
        logic split;   // split into k and f
        logic tab;     // one table step
        logic lin;     // r * ln2
        logic linmul;  // m + m * t
        logic scale;   // mag * m, low half
        logic scale2;  // mag * m, high half
        logic rnd;     // shift, round, clamp
        logic commit;  // update path state
    } dp_cmd_t;

    typedef struct packed {
        logic tab_done;
    } dp_status_t;

    localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [63:0] HALF_Q30  = 64'h2000_0000;

    function automatic logic [31:0] root_entry(input logic [3:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                4'd0:    r = 32'd1518500250;
                4'd1:    r = 32'd1276901417;
                4'd2:    r = 32'd1170923762;
                4'd3:    r = 32'd1121280436;
                4'd4:    r = 32'd1097253708;
                4'd5:    r = 32'd1085434106;
                4'd6:    r = 32'd1079572136;
                4'd7:    r = 32'd1076653033;
                4'd8:    r = 32'd1075196443;
                4'd9:    r = 32'd1074468888;
                4'd10:   r = 32'd1074105295;
                4'd11:   r = 32'd1073923544;
                default: r = 32'd1073741824;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/gbm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_ctrl: sequencing controller
// Walks one item through the datapath steps and handles the result beat.
// ----------------------------------------------------------------------------
module gbm_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire                    in_action,
    input  wire                    log_mode,
    output logic                   out_valid,
    input  wire                    out_stall,
    input  gbm_pkg::dp_status_t    status,
    output gbm_pkg::dp_cmd_t       cmd
);

    gbm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            gbm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_action ? gbm_pkg::ST_NOISE : gbm_pkg::ST_OUT;
                end
            end
            gbm_pkg::ST_NOISE:
            begin
                cmd.noise  = 1'b1;
                state_next = gbm_pkg::ST_EXPO;
            end
            gbm_pkg::ST_EXPO:
            begin
                cmd.expo   = 1'b1;
                state_next = log_mode ? gbm_pkg::ST_ROUND : gbm_pkg::ST_LOG2;
            end
            gbm_pkg::ST_LOG2:
            begin
                cmd.log2m  = 1'b1;
                state_next = gbm_pkg::ST_SPLIT;
            end
            gbm_pkg::ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = gbm_pkg::ST_TAB;
            end
            gbm_pkg::ST_TAB:
            begin
                cmd.tab = 1'b1;
                if (status.tab_done)
                begin
                    state_next = gbm_pkg::ST_LIN;
                end
            end
            gbm_pkg::ST_LIN:
            begin
                cmd.lin    = 1'b1;
                state_next = gbm_pkg::ST_LINMUL;
            end
            gbm_pkg::ST_LINMUL:
            begin
                cmd.linmul = 1'b1;
                state_next = gbm_pkg::ST_SCALE;
            end
            gbm_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = gbm_pkg::ST_SCALE2;
            end
            gbm_pkg::ST_SCALE2:
            begin
                cmd.scale2 = 1'b1;
                state_next = gbm_pkg::ST_ROUND;
            end
            gbm_pkg::ST_ROUND:
            begin
                cmd.rnd    = 1'b1;
                state_next = gbm_pkg::ST_OUT;
            end
            gbm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = gbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/gbm_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_dpath: arithmetic datapath
// Exponent, exp factor by table and linear term, scaling and path state.
// ----------------------------------------------------------------------------
module gbm_dpath #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  gbm_pkg::dp_cmd_t       cmd,
    output gbm_pkg::dp_status_t    status,
    input  wire                    in_action,
    input  wire signed [15:0]      in_sample,
    input  wire signed [47:0]      initial_value,
    input  wire signed [31:0]      drift_term,
    input  wire        [31:0]      diffusion_gain,
    input  wire        [31:0]      tick_step,
    input  wire                    log_mode,
    output logic       [31:0]      step_index,
    output logic       [47:0]      timestamp,
    output logic signed [47:0]     value,
    output logic                   saturated
);

    localparam int TB    = EXP_TABLE_BITS;
    localparam int RBITS = 24 - TB;
    localparam int CW    = (TB > 1) ? $clog2(TB + 1) : 1;

    localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VMIN = -48'sh8000_0000_0000;

    logic              act_reg;
    logic signed [15:0] samp_reg;
    logic signed [48:0] prod_reg;
    logic signed [49:0] e_reg;
    logic [62:0]       y_reg;
    logic signed [8:0] k_reg;
    logic [23:0]       f_reg;
    logic [31:0]       m_reg;
    logic [CW-1:0]     cnt_reg;
    logic [31:0]       t_reg;
    logic [47:0]       mag_reg;
    logic              neg_reg;
    logic [63:0]       lo_reg;
    logic [79:0]       pm_reg;
    logic signed [47:0] val_reg;
    logic              sat_reg;
    logic signed [47:0] cur_reg;
    logic [31:0]       cnt32_reg;
    logic [47:0]       time_reg;

    // noise with round half up, then drift
    logic signed [49:0] noise_w;
    assign noise_w = 50'(prod_reg + 49'sd2048) >>> 12;

    logic signed [31:0] xcl;
    always_comb
    begin
        if (e_reg > 50'sd1073741824)
            xcl = 32'sd1073741824;
        else if (e_reg < -50'sd1073741824)
            xcl = -32'sd1073741824;
        else
            xcl = 32'(e_reg);
    end

    logic [31:0] ybias_w;
    assign ybias_w = 32'(y_reg[62:30] - 33'(gbm_pkg::LOG2E_Q30) + 33'h8000_0000);

    logic [3:0]  tidx;
    logic        fbit;
    logic [63:0] tprod;
    assign tidx  = 4'(cnt_reg);
    assign fbit  = f_reg[5'(23 - int'(cnt_reg))];
    assign tprod = 64'(m_reg) * 64'(gbm_pkg::root_entry(tidx)) + gbm_pkg::HALF_Q30;

    logic [23:0] r_w;
    assign r_w = f_reg & 24'((1 << RBITS) - 1);

    logic [63:0] linp;
    assign linp = 64'(m_reg) * 64'(t_reg) + gbm_pkg::HALF_Q30;

    logic signed [9:0] sh_w;
    assign sh_w = 10'(k_reg) - 10'sd30;

    // magnitude shift and round for the exp path
    logic [127:0] full_w, rs_w;
    logic         ovf_w;
    logic [47:0]  res_w;
    logic [6:0]   n_w;
    always_comb
    begin
        full_w = {48'd0, pm_reg};
        rs_w   = '0;
        ovf_w  = 1'b0;
        n_w    = 7'(-sh_w);
        if (sh_w >= 0)
        begin
            if (sh_w >= 10'sd48)
                ovf_w = 1'b1;
            rs_w = full_w << sh_w[5:0];
            if (rs_w[127:47] != 0)
                ovf_w = 1'b1;
        end
        else if (sh_w < -10'sd80)
        begin
            rs_w = '0;
        end
        else
        begin
            rs_w = (full_w + (128'd1 << (n_w - 7'd1))) >> n_w;
            if (rs_w[127:47] != 0)
                ovf_w = 1'b1;
        end
        res_w = rs_w[47:0];
    end

    logic signed [50:0] lsum;
    assign lsum = 51'(cur_reg) + 51'(e_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_action;
            samp_reg <= in_sample;
        end
        if (cmd.noise)
            prod_reg <= $signed({1'b0, diffusion_gain}) * samp_reg;
        if (cmd.expo)
            e_reg <= noise_w + 50'(drift_term);
        if (cmd.log2m)
            y_reg <= 63'(unsigned'(xcl + 32'sd1073741824)) * 63'(gbm_pkg::LOG2E_Q30);
        if (cmd.split)
        begin
            k_reg   <= $signed(9'(ybias_w[31:24])) - 9'sd128;
            f_reg   <= ybias_w[23:0];
            m_reg   <= gbm_pkg::ONE_Q30;
            cnt_reg <= '0;
            neg_reg <= cur_reg[47];
            mag_reg <= cur_reg[47] ? 48'(-cur_reg) : 48'(cur_reg);
        end
        if (cmd.tab && !status.tab_done)
        begin
            if (fbit)
                m_reg <= tprod[61:30];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.lin)
            t_reg <= 32'((64'(r_w) * gbm_pkg::LN2_Q30) >> 24);
        if (cmd.linmul)
            m_reg <= m_reg + linp[61:30];
        if (cmd.scale)
            lo_reg <= 64'(mag_reg[31:0]) * 64'(m_reg);
        if (cmd.scale2)
            pm_reg <= 80'(lo_reg) + ((80'(mag_reg[47:32]) * 80'(m_reg)) << 32);
        if (cmd.rnd)
        begin
            sat_reg <= 1'b0;
            if (log_mode)
            begin
                if (lsum > 51'(VMAX))
                begin
                    val_reg <= VMAX;
                    sat_reg <= 1'b1;
                end
                else if (lsum < 51'(VMIN))
                begin
                    val_reg <= VMIN;
                    sat_reg <= 1'b1;
                end
                else
                    val_reg <= 48'(lsum);
            end
            else if (cur_reg == 0)
                val_reg <= '0;
            else if (ovf_w && !(neg_reg && sh_w < 10'sd48 && res_w == 48'h8000_0000_0000
                                && rs_w[127:48] == 0))
            begin
                val_reg <= neg_reg ? VMIN : VMAX;
                sat_reg <= 1'b1;
            end
            else
                val_reg <= neg_reg ? 48'(-res_w) : res_w;
        end
    end

    assign status.tab_done = (int'(cnt_reg) >= TB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            cnt32_reg <= '0;
            time_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (!act_reg)
            begin
                cur_reg   <= initial_value;
                cnt32_reg <= '0;
                time_reg  <= '0;
            end
            else
            begin
                cur_reg   <= val_reg;
                cnt32_reg <= cnt32_reg + 1'b1;
                time_reg  <= time_reg + 48'(tick_step);
            end
        end
    end

    assign step_index = act_reg ? cnt32_reg + 1'b1 : '0;
    assign timestamp  = act_reg ? time_reg + 48'(tick_step) : '0;
    assign value      = act_reg ? val_reg : initial_value;
    assign saturated  = act_reg ? sat_reg : 1'b0;

endmodule
`default_nettype wire

// ----- hdl/gbm_path_step_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_path_step_unit: geometric Brownian motion path stepper
// Emits one path point per input beat, by exact exp step or log increment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): action 0 starts a path at
//   initial_value, action 1 advances one step using normal_sample.
//   Output channel (out_valid / out_stall): one beat per input beat with
//   step_index, timestamp, value and saturated.
//   Configure through the APB port while idle; writes land on the
//   access cycle. Reads return the stored register.
// Sequencing:
//   A start goes straight to the result beat; a log step runs noise, drift
//   and round; an exp step adds log2, split, the table multiplier (one table
//   bit per cycle), linear and scale steps. One item is in flight at a time.
// Reset:
//   Path state clears to zero; registers take their documented defaults.
// Stall:
//   The result beat holds on the output until taken; path state updates
//   when the beat is taken, and no new input is accepted meanwhile.
// ----------------------------------------------------------------------------
module gbm_path_step_unit #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [5:0]        paddr,
    input  wire  [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire               action,
    input  wire signed [15:0] normal_sample,
    output logic              out_valid,
    input  wire               out_stall,
    output logic [31:0]       step_index,
    output logic [47:0]       timestamp,
    output logic signed [47:0] value,
    output logic              saturated
);

    logic signed [47:0] init_reg;
    logic signed [31:0] drift_reg;
    logic [31:0]        gain_reg;
    logic [31:0]        tstep_reg;
    logic               log_reg;

    gbm_pkg::dp_cmd_t    cmd;
    gbm_pkg::dp_status_t status;

    logic               wr_en;
    gbm_pkg::reg_index_t widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = gbm_pkg::reg_index_t'(paddr[5:3]);

    // register file, 8-byte spacing since initial_value is 48 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= 48'sd16777216;
            drift_reg <= '0;
            gain_reg  <= '0;
            tstep_reg <= 32'd1;
            log_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (widx)
                gbm_pkg::REG_INIT:  init_reg  <= pwdata[47:0];
                gbm_pkg::REG_DRIFT: drift_reg <= pwdata[31:0];
                gbm_pkg::REG_GAIN:  gain_reg  <= pwdata[31:0];
                gbm_pkg::REG_TSTEP: tstep_reg <= pwdata[31:0];
                gbm_pkg::REG_LOG:   log_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            gbm_pkg::REG_INIT:  prdata = 64'(unsigned'(init_reg));
            gbm_pkg::REG_DRIFT: prdata = 64'(unsigned'(drift_reg));
            gbm_pkg::REG_GAIN:  prdata = 64'(gain_reg);
            gbm_pkg::REG_TSTEP: prdata = 64'(tstep_reg);
            gbm_pkg::REG_LOG:   prdata = 64'(log_reg);
            default:            prdata = '0;
        endcase
    end

    gbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_action (action),
        .log_mode  (log_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gbm_dpath #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_action      (action),
        .in_sample      (normal_sample),
        .initial_value  (init_reg),
        .drift_term     (drift_reg),
        .diffusion_gain (gain_reg),
        .tick_step      (tstep_reg),
        .log_mode       (log_reg),
        .step_index     (step_index),
        .timestamp      (timestamp),
        .value          (value),
        .saturated      (saturated)
    );

    // input and output never handshake in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input open while result pending");

    // an accepted beat leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second beat accepted back to back");

    // a start beat reports no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_index == 32'd0 && timestamp == 48'd0 && value == init_reg
         && $past(in_valid && !in_stall && !action)) |-> !saturated)
        else $error("start beat flagged saturated");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gbm_path_step_unit
// Drives start and step beats, predicts each path point with an independent
// fixed-point model of the exact GBM step and compares every output beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TAB_BITS = 8;
    localparam longint EXP_LIM = 64'sd1 << 30;      // exponent clamp, 64.0 in Q.24
    localparam longint VAL_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint VAL_MIN = -(64'sh8000_0000_0000);
    localparam logic [63:0] MAG_LIM = 64'h8000_0000_0000;
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic        act;
        logic [15:0] sample;
    } path_beat_t;

    typedef struct packed {
        logic [31:0] step_index;
        logic [47:0] timestamp;
        logic [47:0] value;
        logic        saturated;
    } path_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic signed [15:0] normal_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] step_index;
    logic [47:0] timestamp;
    logic signed [47:0] value;
    logic saturated;

    gbm_path_step_unit #(.EXP_TABLE_BITS(TAB_BITS)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .normal_sample(normal_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .step_index(step_index), .timestamp(timestamp),
        .value(value), .saturated(saturated)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // 2^(2^-(i+1)) in Q2.30
    logic [31:0] root_tab [0:11] = '{
        32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
        32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
        32'd1075196443, 32'd1074468888, 32'd1074105295, 32'd1073923544};

    // shadow registers and path state
    logic signed [47:0] cfg_init = 48'sd16777216;
    logic [31:0] cfg_drift = '0, cfg_gain = '0, cfg_tstep = 32'd1;
    logic        cfg_log = 1'b0;
    logic signed [47:0] path_value = '0;
    logic [31:0] path_steps = '0;
    logic [47:0] path_ticks = '0;

    path_beat_t  pending_beats [$];
    path_point_t expected_points [$];
    int errors = 0;
    int src_idle_pct = 0, sink_stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_cnt = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // 2^frac(x*log2e) in Q2.30, integer part in k
    function automatic logic [63:0] exp2_factor(input longint x, output int k);
        logic [63:0] xb, f, m, r, t;
        longint y, yb;
        if (x > EXP_LIM) x = EXP_LIM;
        if (x < -EXP_LIM) x = -EXP_LIM;
        xb = 64'(x + EXP_LIM);
        y = longint'((xb * gbm_pkg::LOG2E_Q30) >> 30) - longint'(gbm_pkg::LOG2E_Q30);
        yb = y + (64'sd128 <<< 24);
        k = int'(yb >>> 24) - 128;
        f = 64'(yb) & 64'hFF_FFFF;
        m = 64'(gbm_pkg::ONE_Q30);
        for (int i = 0; i < TAB_BITS; i++)
            if (f[23 - i])
                m = (m * 64'(root_tab[i]) + gbm_pkg::HALF_Q30) >> 30;
        r = f & ((64'd1 << (24 - TAB_BITS)) - 1);
        t = (r * gbm_pkg::LN2_Q30) >> 24;
        m = m + ((m * t + gbm_pkg::HALF_Q30) >> 30);
        return m;
    endfunction

    function automatic longint scale_by_exp(input longint p, input longint x,
                                            output logic sat);
        logic neg;
        logic [63:0] mag, m, res, lim;
        logic [127:0] prod, q;
        int k, sh, n;
        sat = 1'b0;
        if (p == 0) return 0;
        neg = p < 0;
        mag = neg ? 64'(-p) : 64'(p);
        m = exp2_factor(x, k);
        sh = k - 30;
        if (sh >= 48)
        begin
            sat = 1'b1;
            return neg ? VAL_MIN : VAL_MAX;
        end
        prod = 128'(mag) * 128'(m);
        if (sh >= 0)
        begin
            lim = MAG_LIM >> sh;
            if (prod[127:64] != 0 || prod[63:0] > lim)
            begin
                sat = 1'b1;
                return neg ? VAL_MIN : VAL_MAX;
            end
            res = prod[63:0] << sh;
        end
        else
        begin
            n = -sh;
            if (n > 80) return 0;
            // round half away from zero on the magnitude
            prod = prod + (128'd1 << (n - 1));
            q = prod >> n;
            if (q[127:64] != 0)
            begin
                sat = 1'b1;
                return neg ? VAL_MIN : VAL_MAX;
            end
            res = q[63:0];
        end
        if (neg)
        begin
            if (res > MAG_LIM)
            begin
                sat = 1'b1;
                return VAL_MIN;
            end
            return -longint'(res);
        end
        if (res > 64'(VAL_MAX))
        begin
            sat = 1'b1;
            return VAL_MAX;
        end
        return longint'(res);
    endfunction

    // advance the shadow path by one accepted beat and return its point
    function automatic path_point_t advance_path(input path_beat_t b);
        path_point_t pt;
        longint prod, e, sum, nv;
        logic sat;
        sat = 1'b0;
        if (b.act == ACT_START)
        begin
            path_value = cfg_init;
            path_steps = '0;
            path_ticks = '0;
        end
        else
        begin
            prod = longint'({32'b0, cfg_gain}) * longint'($signed(b.sample));
            e = longint'($signed(cfg_drift)) + ((prod + 2048) >>> 12);
            path_steps = path_steps + 1;
            path_ticks = path_ticks + 48'(cfg_tstep);
            if (cfg_log)
            begin
                sum = longint'(path_value) + e;
                nv = sum;
                if (sum > VAL_MAX) begin nv = VAL_MAX; sat = 1'b1; end
                if (sum < VAL_MIN) begin nv = VAL_MIN; sat = 1'b1; end
            end
            else
                nv = scale_by_exp(longint'(path_value), e, sat);
            path_value = 48'(nv);
        end
        pt.step_index = path_steps;
        pt.timestamp = path_ticks;
        pt.value = path_value;
        pt.saturated = sat;
        return pt;
    endfunction

    // driver: predict on accept, then hold, advance or drop valid
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            expected_points.insert(expected_points.size(),
                                   advance_path('{action, normal_sample}));
        if (in_valid && in_stall)
            ;   // hold the stalled beat
        else if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            path_beat_t b;
            b = pending_beats.pop_front();
            in_valid <= 1'b1;
            action <= b.act;
            normal_sample <= b.sample;
        end
        else
            in_valid <= 1'b0;
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor: check each taken output beat against the oldest prediction
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected beat value", 64'(value), 64'd0);
            end
            else
            begin
                path_point_t w;
                w = expected_points.pop_front();
                if (step_index !== w.step_index)
                    report_mismatch("step_index", 64'(step_index), 64'(w.step_index));
                if (timestamp !== w.timestamp)
                    report_mismatch("timestamp", 64'(timestamp), 64'(w.timestamp));
                if (value !== w.value)
                    report_mismatch("value", 64'(value), 64'(w.value));
                if (saturated !== w.saturated)
                    report_mismatch("saturated", 64'(saturated), 64'(w.saturated));
            end
        end
        out_stall <= (hold_cnt > 1) || ($urandom_range(99) < sink_stall_pct);
    end

    task automatic write_reg(input gbm_pkg::reg_index_t idx, input logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(idx) << 3;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            gbm_pkg::REG_INIT:  cfg_init = data[47:0];
            gbm_pkg::REG_DRIFT: cfg_drift = data[31:0];
            gbm_pkg::REG_GAIN:  cfg_gain = data[31:0];
            gbm_pkg::REG_TSTEP: cfg_tstep = data[31:0];
            gbm_pkg::REG_LOG:   cfg_log = data[0];
            default: ;
        endcase
    endtask

    task automatic push_beat(input logic act, input logic [15:0] s);
        pending_beats.insert(pending_beats.size(), '{act, s});
    endtask

    // wait until every beat is sent and every point is back
    task automatic drain;
        while (pending_beats.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_config(input int p);
        logic [63:0] init;
        init = 64'($urandom_range(1, 4000)) << 20;
        if ($urandom_range(3) == 0) init = -init;
        if (p % 5 == 4) init = {$urandom, $urandom};
        write_reg(gbm_pkg::REG_INIT, init);
        write_reg(gbm_pkg::REG_DRIFT,
                  64'(32'($signed($urandom_range(0, 400000)) - 200000)));
        write_reg(gbm_pkg::REG_GAIN,
                  (p % 5 == 3) ? 64'($urandom) : 64'($urandom_range(0, 6000000)));
        write_reg(gbm_pkg::REG_TSTEP, 64'($urandom));
        write_reg(gbm_pkg::REG_LOG, 64'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // step before any start, then a unit path with zero exponent
        push_beat(ACT_STEP, 16'h0000);
        push_beat(ACT_START, 16'hFFFF);
        push_beat(ACT_STEP, 16'h7FFF);
        push_beat(ACT_STEP, 16'h8000);
        drain();

        // extreme noise and negative drift: price decays to zero and stays
        write_reg(gbm_pkg::REG_GAIN, 64'hFFFF_FFFF);
        write_reg(gbm_pkg::REG_DRIFT, 64'h8000_0000);
        write_reg(gbm_pkg::REG_TSTEP, 64'hFFFF_FFFF);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h8000);
        push_beat(ACT_STEP, 16'h7FFF);
        push_beat(ACT_STEP, 16'h0001);
        drain();

        // overflow on both signs in exp mode
        write_reg(gbm_pkg::REG_GAIN, 64'h0);
        write_reg(gbm_pkg::REG_DRIFT, 64'h7FFF_FFFF);
        write_reg(gbm_pkg::REG_INIT, 64'h7FFF_FFFF_FFFF);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h0);
        drain();
        write_reg(gbm_pkg::REG_INIT, 64'hFFFF_8000_0000_0000);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h1234);
        drain();

        // log mode clamps at both limits
        write_reg(gbm_pkg::REG_LOG, 64'h1);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h0);
        drain();
        write_reg(gbm_pkg::REG_DRIFT, 64'h8000_0000);
        push_beat(ACT_STEP, 16'h0);
        drain();
        write_reg(gbm_pkg::REG_INIT, 64'h7FFF_FFFF_FFFF);
        write_reg(gbm_pkg::REG_DRIFT, 64'h7FFF_FFFF);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h0);
        drain();

        // zero price in exp mode
        write_reg(gbm_pkg::REG_LOG, 64'h0);
        write_reg(gbm_pkg::REG_INIT, 64'h0);
        write_reg(gbm_pkg::REG_DRIFT, 64'h0100_0000);
        push_beat(ACT_START, 16'h0);
        push_beat(ACT_STEP, 16'h4000);
        drain();

        // random paths, rotating idle patterns
        for (int p = 0; p < 12; p++)
        begin
            random_config(p);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            push_beat(ACT_START, 16'($urandom));
            for (int i = 0; i < 61; i++)
                push_beat(($urandom_range(19) == 0) ? ACT_START : ACT_STEP,
                          16'($urandom));
            if (p == 4)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("PASS gbm_path_step_unit");
        else
            $display("FAIL gbm_path_step_unit");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL gbm_path_step_unit");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gbm_pkg.sv
hdl/gbm_ctrl.sv
hdl/gbm_dpath.sv
hdl/gbm_path_step_unit.sv
verif/testbench.sv
